>>> hdl/rdpd_pkg.sv
// shared types, constants and register codes for the rotary dial pulse decoder
package rdpd_pkg;

    // number width in digits, and the saturation limits of the counters
    localparam int NUMBER_DIGITS = 8;
    localparam int HELD_W        = $clog2(NUMBER_DIGITS + 1);
    localparam int HOLD_W        = 8;
    localparam int TRAIN_W       = 5;
    localparam int SINCE_PULSE_W = 12;
    localparam int SINCE_DIGIT_W = 17;
    localparam int BCD_W         = 32;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_SETTLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOOK_SETTLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_GAP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_TIMEOUT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSES   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOOK_PRESENT = 3'd5;

    // event codes
    localparam logic [1:0] EV_OFF_HOOK = 2'd0;
    localparam logic [1:0] EV_ON_HOOK  = 2'd1;
    localparam logic [1:0] EV_DIGIT    = 2'd2;
    localparam logic [1:0] EV_NUMBER   = 2'd3;

    // pulses that stand for the digit zero
    localparam logic [TRAIN_W-1:0] TEN_PULSES = 5'd10;

    // result queue
    localparam int MAX_RES     = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [3:0]       digit_value;
        logic [BCD_W-1:0] number_bcd;
        logic             last_of_run;
    } result_t;

endpackage

>>> hdl/rdpd_if.sv
// stream interfaces for the dial input ticks and the decoded events
interface rdpd_in_if;
    logic valid;
    logic ready;
    logic pulse_level;
    logic hook_level;

    modport source (output valid, output pulse_level, output hook_level, input ready);
    modport sink   (input valid, input pulse_level, input hook_level, output ready);
endinterface

interface rdpd_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                event_kind;
    logic [3:0]                digit_value;
    logic [rdpd_pkg::BCD_W-1:0] number_bcd;
    logic                      last_of_run;

    modport source (output valid, output event_kind, output digit_value,
                    output number_bcd, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input digit_value,
                    input number_bcd, input last_of_run, output ready);
endinterface

>>> hdl/rotary_dial_pulse_decoder_top.sv
// Rotary dial pulse decoder: debounce, pulse train count, digit and number assembly.
// Flow: a tick is registered in the input register on transfer, then decoded, and its
// results are written into the result queue, from which they are offered in order.
// Throughput: one tick per cycle while ticks make at most one result each and the
// receiver is ready; the four-entry result queue and the single output port set that figure.
// Reset: all timers, counters and the number clear, the contacts read released and
// lifted, registers take their defaults, and the first tick reports off-hook.
module rotary_dial_pulse_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rdpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rdpd_pkg::CFG_DATA_W-1:0]      cfg_data,
    rdpd_in_if.sink                              dial_in,
    rdpd_out_if.source                           evt_out
);

    // configuration registers
    logic [7:0]  pulse_settle_reg;
    logic [7:0]  hook_settle_reg;
    logic [11:0] digit_gap_reg;
    logic [15:0] num_timeout_reg;
    logic [3:0]  max_pulses_reg;
    logic        hook_present_reg;

    // input register
    logic in_vld_reg;
    logic in_pulse_reg;
    logic in_hook_reg;

    // decoder state
    logic                                  pulse_raw_reg,   pulse_raw_next;
    logic                                  pulse_set_reg,   pulse_set_next;
    logic [rdpd_pkg::HOLD_W-1:0]           pulse_tmr_reg,   pulse_tmr_next;
    logic                                  hook_raw_reg,    hook_raw_next;
    logic                                  hook_set_reg,    hook_set_next;
    logic [rdpd_pkg::HOLD_W-1:0]           hook_tmr_reg,    hook_tmr_next;
    logic                                  lifted_reg,      lifted_next;
    logic [rdpd_pkg::TRAIN_W-1:0]          train_reg,       train_next;
    logic [rdpd_pkg::SINCE_PULSE_W-1:0]    since_pulse_reg, since_pulse_next;
    logic [rdpd_pkg::HELD_W-1:0]           held_reg,        held_next;
    logic [rdpd_pkg::BCD_W-1:0]            number_reg,      number_next;
    logic [rdpd_pkg::SINCE_DIGIT_W-1:0]    since_digit_reg, since_digit_next;
    logic                                  boot_reg,        boot_next;

    // result queue
    rdpd_pkg::result_t                 queue_mem [rdpd_pkg::QUEUE_DEPTH];
    logic [rdpd_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [rdpd_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [rdpd_pkg::QCNT_W-1:0]       q_cnt_reg;

    logic                fire;
    logic                pop;
    rdpd_pkg::result_t   res0;
    rdpd_pkg::result_t   res1;
    logic [1:0]          res_cnt;

    // decode one tick when the queue has room for both possible results
    assign fire = in_vld_reg &&
        (q_cnt_reg <= rdpd_pkg::QCNT_W'(rdpd_pkg::QUEUE_DEPTH - rdpd_pkg::MAX_RES));
    assign dial_in.ready = !in_vld_reg || fire;
    assign pop = evt_out.valid && evt_out.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_settle_reg <= 8'd15;
            hook_settle_reg  <= 8'd30;
            digit_gap_reg    <= 12'd300;
            num_timeout_reg  <= 16'd5000;
            max_pulses_reg   <= 4'd10;
            hook_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdpd_pkg::CFG_PULSE_SETTLE: pulse_settle_reg <= cfg_data[7:0];
                rdpd_pkg::CFG_HOOK_SETTLE:  hook_settle_reg  <= cfg_data[7:0];
                rdpd_pkg::CFG_DIGIT_GAP:    digit_gap_reg    <= cfg_data[11:0];
                rdpd_pkg::CFG_NUM_TIMEOUT:  num_timeout_reg  <= cfg_data[15:0];
                rdpd_pkg::CFG_MAX_PULSES:   max_pulses_reg   <= cfg_data[3:0];
                rdpd_pkg::CFG_HOOK_PRESENT: hook_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (dial_in.ready)
        begin
            in_vld_reg <= dial_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dial_in.valid && dial_in.ready)
        begin
            in_pulse_reg <= dial_in.pulse_level;
            in_hook_reg  <= dial_in.hook_level;
        end
    end

    // tick decode
    always_comb
    begin
        logic       pulse_chg;
        logic       hook_chg;
        logic [3:0] limit;
        logic [3:0] digit;
        logic       train_end;
        logic [rdpd_pkg::TRAIN_W-1:0] count;
        rdpd_pkg::result_t cand;

        pulse_raw_next   = pulse_raw_reg;
        pulse_set_next   = pulse_set_reg;
        pulse_tmr_next   = pulse_tmr_reg;
        hook_raw_next    = hook_raw_reg;
        hook_set_next    = hook_set_reg;
        hook_tmr_next    = hook_tmr_reg;
        lifted_next      = lifted_reg;
        train_next       = train_reg;
        held_next        = held_reg;
        number_next      = number_reg;
        boot_next        = 1'b0;
        res0             = '0;
        res1             = '0;
        res_cnt          = 2'd0;
        pulse_chg        = 1'b0;
        hook_chg         = 1'b0;
        cand             = '0;
        count            = train_reg;
        digit            = 4'd0;
        limit            = (max_pulses_reg > 4'd10) ? 4'd10 : max_pulses_reg;

        // saturating tick timers
        since_pulse_next = (&since_pulse_reg) ? since_pulse_reg : since_pulse_reg + 1'b1;
        since_digit_next = (&since_digit_reg) ? since_digit_reg : since_digit_reg + 1'b1;

        // first tick reports off-hook
        if (boot_reg)
        begin
            cand = '{event_kind: rdpd_pkg::EV_OFF_HOOK, digit_value: 4'd0,
                     number_bcd: '0, last_of_run: 1'b0};
            res0    = cand;
            res_cnt = 2'd1;
        end

        // impulse contact debounce, a settled release is one pulse
        if (in_pulse_reg != pulse_raw_reg)
        begin
            pulse_raw_next = in_pulse_reg;
            pulse_tmr_next = '0;
        end
        else
        begin
            pulse_tmr_next = (&pulse_tmr_reg) ? pulse_tmr_reg : pulse_tmr_reg + 1'b1;
            if (pulse_tmr_next >= pulse_settle_reg && in_pulse_reg != pulse_set_reg)
            begin
                pulse_set_next = in_pulse_reg;
                pulse_chg      = 1'b1;
            end
        end
        if (pulse_chg && pulse_set_next)
        begin
            train_next       = (&train_reg) ? train_reg : train_reg + 1'b1;
            since_pulse_next = '0;
        end

        // hook contact debounce and hook events
        if (hook_present_reg)
        begin
            if (in_hook_reg != hook_raw_reg)
            begin
                hook_raw_next = in_hook_reg;
                hook_tmr_next = '0;
            end
            else
            begin
                hook_tmr_next = (&hook_tmr_reg) ? hook_tmr_reg : hook_tmr_reg + 1'b1;
                if (hook_tmr_next >= hook_settle_reg && in_hook_reg != hook_set_reg)
                begin
                    hook_set_next = in_hook_reg;
                    hook_chg      = 1'b1;
                end
            end
        end
        if (hook_chg)
        begin
            lifted_next = hook_set_next;
            held_next   = '0;
            number_next = '0;
            train_next  = '0;
            cand = '{event_kind: hook_set_next ? rdpd_pkg::EV_OFF_HOOK : rdpd_pkg::EV_ON_HOOK,
                     digit_value: 4'd0, number_bcd: '0, last_of_run: 1'b0};
            if (res_cnt == 2'd0)
            begin
                res0 = cand;
            end
            else
            begin
                res1 = cand;
            end
            res_cnt = res_cnt + 2'd1;
        end

        // end of train, digit and number assembly
        count     = train_next;
        train_end = (train_next != '0) && (since_pulse_next >= digit_gap_reg);
        if (train_end)
        begin
            train_next = '0;
            if ((lifted_next || !hook_present_reg) && count != '0 &&
                count <= {1'b0, limit})
            begin
                digit = (count == rdpd_pkg::TEN_PULSES) ? 4'd0 : count[3:0];
                if (held_next != '0 &&
                    since_digit_next > {{(rdpd_pkg::SINCE_DIGIT_W-16){1'b0}}, num_timeout_reg})
                begin
                    held_next   = '0;
                    number_next = '0;
                end
                since_digit_next = '0;

                cand = '{event_kind: rdpd_pkg::EV_DIGIT, digit_value: digit,
                         number_bcd: '0, last_of_run: 1'b0};
                if (res_cnt == 2'd0)
                begin
                    res0 = cand;
                    res_cnt = 2'd1;
                end
                else if (res_cnt == 2'd1)
                begin
                    res1 = cand;
                    res_cnt = 2'd2;
                end

                if (held_next < rdpd_pkg::HELD_W'(rdpd_pkg::NUMBER_DIGITS))
                begin
                    number_next = {number_next[rdpd_pkg::BCD_W-5:0], digit};
                    held_next   = held_next + 1'b1;
                end
                if (held_next >= rdpd_pkg::HELD_W'(rdpd_pkg::NUMBER_DIGITS))
                begin
                    cand = '{event_kind: rdpd_pkg::EV_NUMBER, digit_value: 4'd0,
                             number_bcd: number_next, last_of_run: 1'b0};
                    if (res_cnt == 2'd0)
                    begin
                        res0 = cand;
                        res_cnt = 2'd1;
                    end
                    else if (res_cnt == 2'd1)
                    begin
                        res1 = cand;
                        res_cnt = 2'd2;
                    end
                    held_next   = '0;
                    number_next = '0;
                end
            end
        end

        // mark the final result of the tick
        if (res_cnt == 2'd1)
        begin
            res0.last_of_run = 1'b1;
        end
        else if (res_cnt == 2'd2)
        begin
            res1.last_of_run = 1'b1;
        end
    end

    // decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_raw_reg   <= 1'b1;
            pulse_set_reg   <= 1'b1;
            pulse_tmr_reg   <= '0;
            hook_raw_reg    <= 1'b1;
            hook_set_reg    <= 1'b1;
            hook_tmr_reg    <= '0;
            lifted_reg      <= 1'b1;
            train_reg       <= '0;
            since_pulse_reg <= '0;
            held_reg        <= '0;
            number_reg      <= '0;
            since_digit_reg <= '0;
            boot_reg        <= 1'b1;
        end
        else if (fire)
        begin
            pulse_raw_reg   <= pulse_raw_next;
            pulse_set_reg   <= pulse_set_next;
            pulse_tmr_reg   <= pulse_tmr_next;
            hook_raw_reg    <= hook_raw_next;
            hook_set_reg    <= hook_set_next;
            hook_tmr_reg    <= hook_tmr_next;
            lifted_reg      <= lifted_next;
            train_reg       <= train_next;
            since_pulse_reg <= since_pulse_next;
            held_reg        <= held_next;
            number_reg      <= number_next;
            since_digit_reg <= since_digit_next;
            boot_reg        <= boot_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (fire && res_cnt != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (fire && res_cnt == 2'd2)
        begin
            queue_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + rdpd_pkg::QPTR_W'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg
                       + (fire ? rdpd_pkg::QCNT_W'(res_cnt) : '0)
                       - rdpd_pkg::QCNT_W'(pop);
        end
    end

    // output side
    assign evt_out.valid       = (q_cnt_reg != '0);
    assign evt_out.event_kind  = queue_mem[rd_ptr_reg].event_kind;
    assign evt_out.digit_value = queue_mem[rd_ptr_reg].digit_value;
    assign evt_out.number_bcd  = queue_mem[rd_ptr_reg].number_bcd;
    assign evt_out.last_of_run = queue_mem[rd_ptr_reg].last_of_run;

endmodule

>>> verif/tb_rotary_dial_pulse_decoder_top.sv
// testbench for the rotary dial pulse decoder: directed dialing cases, then random dialing
module tb_rotary_dial_pulse_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int FLUSH_CYCLES = 8;
    localparam int GAP_MAX      = 19;

    // debouncer of one contact
    typedef struct {
        bit       raw;
        bit       stable;
        bit [7:0] hold;
    } contact_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rdpd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rdpd_pkg::CFG_DATA_W-1:0]  cfg_data;

    rdpd_in_if  dial_in ();
    rdpd_out_if evt_out ();

    rotary_dial_pulse_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dial_in   (dial_in),
        .evt_out   (evt_out)
    );

    // register copies used by the decoder model
    bit [7:0]  settle_pulse;
    bit [7:0]  settle_hook;
    bit [11:0] train_gap;
    bit [15:0] number_timeout;
    bit [3:0]  pulse_limit;
    bit        hook_wired;

    // decoder model state
    contact_t  pulse_contact;
    contact_t  hook_contact;
    bit        lifted;
    bit [4:0]  pulse_count;
    bit [11:0] quiet_ticks;
    int        digit_count;
    bit [31:0] digits_bcd;
    bit [16:0] pause_ticks;
    bit        boot_pending;

    rdpd_pkg::result_t tick_events[$];
    rdpd_pkg::result_t pending_events[$];

    // run bookkeeping
    bit  sender_gaps_on;
    bit  sink_stalls_on;
    bit  hook_line;
    int  ticks_sent;
    int  settings_used;
    int  error_count;
    int  results_checked;
    int  digits_seen;
    int  numbers_seen;
    int  hook_seen;
    int  cycle_count;

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_events.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void reset_decoder_model();
        settle_pulse   = 8'd15;
        settle_hook    = 8'd30;
        train_gap      = 12'd300;
        number_timeout = 16'd5000;
        pulse_limit    = 4'd10;
        hook_wired     = 1'b1;
        pulse_contact  = '{raw: 1'b1, stable: 1'b1, hold: 8'd0};
        hook_contact   = '{raw: 1'b1, stable: 1'b1, hold: 8'd0};
        lifted         = 1'b1;
        pulse_count    = '0;
        quiet_ticks    = '0;
        digit_count    = 0;
        digits_bcd     = '0;
        pause_ticks    = '0;
        boot_pending   = 1'b1;
    endfunction

    // one debounce step, moved is set when the settled level changes
    function automatic contact_t contact_step(contact_t c, bit lvl, bit [7:0] need,
                                              output bit moved);
        contact_t n;
        n = c;
        moved = 1'b0;
        if (lvl != c.raw)
        begin
            n.raw  = lvl;
            n.hold = '0;
        end
        else
        begin
            if (n.hold != 8'hFF)
                n.hold++;
            if (n.hold >= need && lvl != n.stable)
            begin
                n.stable = lvl;
                moved    = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic void add_event(logic [1:0] kind, logic [3:0] digit, logic [31:0] bcd);
        rdpd_pkg::result_t r;
        if (tick_events.size() < rdpd_pkg::MAX_RES)
        begin
            r.event_kind  = kind;
            r.digit_value = digit;
            r.number_bcd  = bcd;
            r.last_of_run = 1'b0;
            tick_events.push_back(r);
        end
    endfunction

    // a finished train becomes a digit, and maybe completes the number
    function automatic void take_train(bit [4:0] count);
        bit [4:0] ceiling;
        bit [3:0] d;
        ceiling = (pulse_limit > 4'd10) ? 5'd10 : {1'b0, pulse_limit};
        if (count == 0 || count > ceiling)
            return;
        d = (count == rdpd_pkg::TEN_PULSES) ? 4'd0 : count[3:0];
        if (digit_count > 0 && pause_ticks > number_timeout)
        begin
            digit_count = 0;
            digits_bcd  = '0;
        end
        pause_ticks = '0;
        add_event(rdpd_pkg::EV_DIGIT, d, '0);
        if (digit_count < rdpd_pkg::NUMBER_DIGITS)
        begin
            digits_bcd = {digits_bcd[27:0], d};
            digit_count++;
        end
        if (digit_count >= rdpd_pkg::NUMBER_DIGITS)
        begin
            add_event(rdpd_pkg::EV_NUMBER, '0, digits_bcd);
            digit_count = 0;
            digits_bcd  = '0;
        end
    endfunction

    // advance the model by one tick and queue what it reports
    function automatic void predict_tick(bit p, bit h);
        bit                moved;
        bit [4:0]          count;
        rdpd_pkg::result_t r;
        tick_events.delete();
        if (quiet_ticks != 12'hFFF)
            quiet_ticks++;
        if (pause_ticks != 17'h1FFFF)
            pause_ticks++;

        if (boot_pending)
        begin
            boot_pending = 1'b0;
            add_event(rdpd_pkg::EV_OFF_HOOK, '0, '0);
        end

        // released edge of the impulse contact is one pulse
        pulse_contact = contact_step(pulse_contact, p, settle_pulse, moved);
        if (moved && pulse_contact.stable)
        begin
            if (pulse_count != 5'd31)
                pulse_count++;
            quiet_ticks = '0;
        end

        // hook change clears train and number
        if (hook_wired)
        begin
            hook_contact = contact_step(hook_contact, h, settle_hook, moved);
            if (moved)
            begin
                lifted      = hook_contact.stable;
                digit_count = 0;
                digits_bcd  = '0;
                pulse_count = '0;
                add_event(lifted ? rdpd_pkg::EV_OFF_HOOK : rdpd_pkg::EV_ON_HOOK, '0, '0);
            end
        end

        // train ends after a quiet gap
        if (pulse_count != 0 && quiet_ticks >= train_gap)
        begin
            count       = pulse_count;
            pulse_count = '0;
            if (lifted || !hook_wired)
                take_train(count);
        end

        for (int i = 0; i < tick_events.size(); i++)
        begin
            r = tick_events[i];
            r.last_of_run = (i == tick_events.size() - 1);
            pending_events.push_back(r);
        end
    endfunction

    function automatic void log_failure(string what, rdpd_pkg::result_t want,
                                        rdpd_pkg::result_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: expected kind %0d digit %0d bcd %h last %0b,",
                     $time, what, want.event_kind, want.digit_value, want.number_bcd,
                     want.last_of_run,
                     " got kind %0d digit %0d bcd %h last %0b",
                     got.event_kind, got.digit_value, got.number_bcd, got.last_of_run);
    endfunction

    // result checker
    always @(posedge clk)
    begin : event_check
        rdpd_pkg::result_t want;
        rdpd_pkg::result_t got;
        if (rst_n && evt_out.valid && evt_out.ready)
        begin
            got.event_kind  = evt_out.event_kind;
            got.digit_value = evt_out.digit_value;
            got.number_bcd  = evt_out.number_bcd;
            got.last_of_run = evt_out.last_of_run;
            results_checked++;
            if (pending_events.size() == 0)
            begin
                log_failure("unexpected result", '0, got);
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.event_kind !== want.event_kind ||
                    got.digit_value !== want.digit_value ||
                    got.number_bcd !== want.number_bcd ||
                    got.last_of_run !== want.last_of_run)
                    log_failure("result mismatch", want, got);
                unique case (want.event_kind)
                    rdpd_pkg::EV_DIGIT:  digits_seen++;
                    rdpd_pkg::EV_NUMBER: numbers_seen++;
                    default:             hook_seen++;
                endcase
            end
        end
    end

    // receiver ready with random stall bursts
    initial
    begin : sink_stall
        evt_out.ready <= 1'b1;
        forever
        begin
            if (sink_stalls_on && $urandom_range(0, 3) == 0)
            begin
                evt_out.ready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
            end
            evt_out.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // one tick transfer, with an optional idle burst after it
    task automatic send_tick(bit p, bit h);
        dial_in.valid       <= 1'b1;
        dial_in.pulse_level <= p;
        dial_in.hook_level  <= h;
        @(posedge clk);
        while (!dial_in.ready)
            @(posedge clk);
        predict_tick(p, h);
        ticks_sent++;
        if (sender_gaps_on && $urandom_range(0, 5) == 0)
        begin
            dial_in.valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        end
    endtask

    task automatic hold_levels(bit p, bit h, int n);
        repeat (n) send_tick(p, h);
    endtask

    // pulses of the impulse contact, then released for quiet_len ticks
    task automatic dial_digit(int pulses, int close_len, int open_len, int quiet_len);
        repeat (pulses)
        begin
            hold_levels(1'b0, hook_line, close_len);
            hold_levels(1'b1, hook_line, open_len);
        end
        hold_levels(1'b1, hook_line, quiet_len);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        dial_in.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    // write all six registers back to back, only while idle
    task automatic program_dial(int ps, int hs, int gap, int tmo, int mp, int hp);
        logic [rdpd_pkg::CFG_INDEX_W-1:0] idx [6];
        int                               val [6];
        idx = '{rdpd_pkg::CFG_PULSE_SETTLE, rdpd_pkg::CFG_HOOK_SETTLE,
                rdpd_pkg::CFG_DIGIT_GAP, rdpd_pkg::CFG_NUM_TIMEOUT,
                rdpd_pkg::CFG_MAX_PULSES, rdpd_pkg::CFG_HOOK_PRESENT};
        val = '{ps, hs, gap, tmo, mp, hp};
        wait_idle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= rdpd_pkg::CFG_DATA_W'(val[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settle_pulse   = ps[7:0];
        settle_hook    = hs[7:0];
        train_gap      = gap[11:0];
        number_timeout = tmo[15:0];
        pulse_limit    = mp[3:0];
        hook_wired     = hp[0];
        settings_used++;
    endtask

    // boot report, register defaults, one slow digit and a slow hook cycle
    task automatic test_boot_defaults();
        hold_levels(1'b1, 1'b1, 2);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        dial_digit(1, 17, 17, 302);
        hold_levels(1'b1, 1'b0, 33);
        hold_levels(1'b1, 1'b1, 33);
        wait_idle();
    endtask

    // every digit value, ten pulses as zero, a full number, a saturated train
    task automatic test_digit_values();
        program_dial(0, 0, 4, 65535, 10, 1);
        for (int n = 1; n <= 10; n++)
            dial_digit(n, 2, 2, 4);
        dial_digit(33, 2, 2, 4);
        hold_levels(1'b1, 1'b0, 3);
        hold_levels(1'b1, 1'b1, 3);
        wait_idle();
    endtask

    // pulse count limit at zero, one, mid and above ten
    task automatic test_count_limits();
        int lim [4];
        int top;
        lim = '{0, 1, 3, 15};
        foreach (lim[i])
        begin
            program_dial(0, 0, 4, 65535, lim[i], 1);
            top = (lim[i] > 10) ? 10 : lim[i];
            dial_digit(1, 2, 2, 4);
            dial_digit(top, 2, 2, 4);
            dial_digit(top + 1, 2, 2, 4);
        end
        wait_idle();
    endtask

    // zero gap: every pulse is a digit of its own
    task automatic test_zero_gap();
        program_dial(0, 0, 0, 65535, 10, 1);
        dial_digit(3, 2, 2, 4);
        wait_idle();
    endtask

    // stale partial number is dropped, zero timeout drops every time
    task automatic test_stale_number();
        program_dial(0, 0, 4, 20, 10, 1);
        dial_digit(2, 2, 2, 4);
        dial_digit(3, 2, 2, 4);
        hold_levels(1'b1, hook_line, 30);
        dial_digit(4, 2, 2, 4);
        repeat (7) dial_digit(1, 2, 2, 4);
        program_dial(0, 0, 4, 0, 10, 1);
        repeat (3) dial_digit(1, 2, 2, 4);
        wait_idle();
    endtask

    // hook events, dialing on the cradle, hook absent
    task automatic test_hook_events();
        program_dial(0, 2, 4, 65535, 10, 1);
        hook_line = 1'b0;
        hold_levels(1'b1, hook_line, 5);
        dial_digit(3, 2, 2, 4);
        hook_line = 1'b1;
        hold_levels(1'b1, hook_line, 5);
        dial_digit(2, 2, 2, 4);
        hold_levels(1'b1, 1'b0, 5);
        hold_levels(1'b1, 1'b1, 5);
        // short hook bounce that never settles
        hold_levels(1'b1, 1'b0, 2);
        hold_levels(1'b1, 1'b1, 5);
        program_dial(0, 2, 4, 65535, 10, 0);
        hook_line = 1'b0;
        hold_levels(1'b1, hook_line, 5);
        dial_digit(5, 2, 2, 4);
        hook_line = 1'b1;
        wait_idle();
    endtask

    // slow pulse settle and a long gap
    task automatic test_slow_extremes();
        program_dial(20, 0, 50, 65535, 10, 1);
        dial_digit(1, 22, 22, 52);
        wait_idle();
    endtask

    // random settings per phase, mostly clean dialing with noise mixed in
    task automatic run_random_phases(int wanted);
        int start;
        int ps, hs, gap, tmo, mp, hp, good, base, pick, pulses;
        start = ticks_sent;
        while (ticks_sent - start < wanted)
        begin
            ps   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            hs   = $urandom_range(0, 4);
            good = (ps + 1 > 2) ? ps + 1 : 2;
            base = 2 * good + 4;
            gap  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, base)
                                               : base + $urandom_range(1, 6);
            pick = $urandom_range(0, 9);
            tmo  = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(30, 300);
            mp   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 10;
            hp   = ($urandom_range(0, 6) == 0) ? 0 : 1;
            program_dial(ps, hs, gap, tmo, mp, hp);
            repeat ($urandom_range(2, 5))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // clean digit
                    pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14)
                                                         : $urandom_range(1, 10);
                    repeat (pulses)
                    begin
                        hold_levels(1'b0, hook_line, good + $urandom_range(0, 2));
                        hold_levels(1'b1, hook_line, good + $urandom_range(0, 2));
                    end
                    hold_levels(1'b1, hook_line, gap + $urandom_range(1, 4));
                end
                else if (pick < 80)
                begin
                    // contact noise
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(0, 1)), hook_line);
                end
                else if (pick < 88)
                begin
                    // hook change
                    hook_line = !hook_line;
                    hold_levels(1'b1, hook_line, hs + 2 + $urandom_range(0, 3));
                end
                else if (pick < 95)
                begin
                    // pause long enough to drop a partial number
                    if (tmo <= 300)
                        hold_levels(1'b1, hook_line, tmo + $urandom_range(1, 20));
                end
                else
                begin
                    // bouncy train
                    repeat ($urandom_range(1, 6))
                    begin
                        hold_levels(1'b0, hook_line, $urandom_range(1, good));
                        hold_levels(1'b1, hook_line, $urandom_range(1, good));
                    end
                    hold_levels(1'b1, hook_line, $urandom_range(0, gap + 2));
                end
            end
        end
        wait_idle();
    endtask

    task automatic test_random_dialing();
        run_random_phases(150);
    endtask

    // last stretch with no idle on either side
    task automatic test_steady_stream();
        wait_idle();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        // let a receiver stall already under way run out
        repeat (GAP_MAX + 1) @(posedge clk);
        run_random_phases(100);
    endtask

    // main sequence
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        dial_in.valid       <= 1'b0;
        dial_in.pulse_level <= 1'b1;
        dial_in.hook_level  <= 1'b1;
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        hook_line      = 1'b1;
        reset_decoder_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boot_defaults();
        test_digit_values();
        test_count_limits();
        test_zero_gap();
        test_stale_number();
        test_hook_events();
        test_slow_extremes();
        test_random_dialing();
        test_steady_stream();

        wait_idle();
        $display("sent %0d ticks under %0d register settings with sender and receiver stalls",
                 ticks_sent, settings_used);
        $display("checked %0d events: %0d digits, %0d numbers, %0d hook reports, %0d errors",
                 results_checked, digits_seen, numbers_seen, hook_seen, error_count);
        if (error_count == 0 && pending_events.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
